// File: src/bitmap_id_allocator_with_overflow_defines.svh
// Assertion macros shared by the identifier allocator RTL.
`ifndef BITMAP_ID_ALLOCATOR_WITH_OVERFLOW_DEFINES_SVH
`define BITMAP_ID_ALLOCATOR_WITH_OVERFLOW_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define BIA_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define BIA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: src/bia_pkg.sv
// Package with the constants, types and codes of the identifier allocator.
`default_nettype none

package bia_pkg;

   localparam int MAP_BITS      = 256;
   localparam int CONTEXT_COUNT = 4;
   localparam int IDX_W         = $clog2(MAP_BITS);
   localparam int CTX_W         = (CONTEXT_COUNT > 1) ? $clog2(CONTEXT_COUNT) : 1;
   localparam int CTX_IN_W      = 3;
   localparam int ID_W          = 16;
   localparam int STATUS_W      = 2;
   localparam int CFG_W         = 8;
   localparam int ADDR_W        = 3;
   localparam int REG_IDX_W     = ADDR_W - 2;
   localparam int DATA_W        = 32;

   localparam logic [CFG_W-1:0]     RESERVED_RESET     = 8'd2;
   localparam logic [ID_W-1:0]      ID_LIMIT           = 16'hFFFF;
   localparam logic [ID_W-1:0]      MAP_ID             = ID_W'(MAP_BITS);
   localparam logic [REG_IDX_W-1:0] REG_RESERVED_COUNT = 1'b0;

   typedef logic [MAP_BITS-1:0] map_type;
   typedef logic [ID_W-1:0]     id_type;

   typedef enum logic {
      CMD_ALLOC   = 1'b0,
      CMD_RELEASE = 1'b1
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK          = 2'd0,
      STATUS_BAD_CONTEXT = 2'd1,
      STATUS_EXHAUSTED   = 2'd2
   } status_type;

endpackage

`default_nettype wire

// File: src/bitmap_id_allocator_with_overflow.sv
// Top level of the per-context bitmap identifier allocator with overflow counter.
// A request is registered at acceptance and its result when it leaves the request stage.
// Throughput: one request per cycle if rsp_stall is low; a bitmap's find-first-clear sets it.
// Reset is synchronous and clears all bitmaps, overflow counters and maxima at once.
// The reserved count returns to two at reset and no clearing pass is needed.
`default_nettype none
`include "bitmap_id_allocator_with_overflow_defines.svh"

module bitmap_id_allocator_with_overflow (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic                          req_cmd,
   input  wire logic [bia_pkg::CTX_IN_W-1:0]  req_context_req,
   input  wire logic [bia_pkg::ID_W-1:0]      req_release_id,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic [bia_pkg::ID_W-1:0]           rsp_given_id,
   output logic [bia_pkg::STATUS_W-1:0]       rsp_status,
   input  wire logic                          psel,
   input  wire logic                          penable,
   input  wire logic                          pwrite,
   input  wire logic [bia_pkg::ADDR_W-1:0]    paddr,
   input  wire logic [bia_pkg::DATA_W-1:0]    pwdata,
   output logic [bia_pkg::DATA_W-1:0]         prdata,
   output logic                               pready
);

   logic                              s1_valid_ff, s1_valid_in;
   bia_pkg::cmd_type                  s1_cmd_ff;
   logic [bia_pkg::CTX_IN_W-1:0]      s1_ctx_ff;
   bia_pkg::id_type                   s1_rid_ff;

   logic                              rsp_valid_ff, rsp_valid_in;
   bia_pkg::id_type                   rsp_given_id_ff, rsp_given_id_in;
   bia_pkg::status_type               rsp_status_ff, rsp_status_in;

   bia_pkg::map_type                  used_bits_ff [bia_pkg::CONTEXT_COUNT];
   bia_pkg::id_type                   overflow_count_ff [bia_pkg::CONTEXT_COUNT];
   bia_pkg::id_type                   overflow_max_ff [bia_pkg::CONTEXT_COUNT];
   logic [bia_pkg::CFG_W-1:0]         reserved_count_ff, reserved_count_in;

   logic                              accept, s1_go, csr_write;
   logic [bia_pkg::REG_IDX_W-1:0]     reg_index;

   logic                              ctx_ok, found, exhausted, state_we;
   logic [bia_pkg::CTX_W-1:0]         ctx_idx;
   bia_pkg::map_type                  cur_map, ge_mask, cand, fill, lowest, map_in;
   bia_pkg::id_type                   cur_count, cur_max, count_in, max_in, dec_count;
   logic [bia_pkg::IDX_W-1:0]         alloc_idx;

   assign s1_go       = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall   = s1_valid_ff && rsp_valid_ff && rsp_stall;
   assign accept      = req_valid && !req_stall;
   assign s1_valid_in = accept || (s1_valid_ff && !s1_go);
   assign rsp_valid_in = s1_go || (rsp_valid_ff && rsp_stall);

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_given_id = rsp_given_id_ff;
   assign rsp_status   = rsp_status_ff;

   assign pready    = 1'b1;
   assign reg_index = paddr[bia_pkg::ADDR_W-1:2];
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      reserved_count_in = reserved_count_ff;
      if (csr_write && (reg_index == bia_pkg::REG_RESERVED_COUNT)) begin
         reserved_count_in = pwdata[bia_pkg::CFG_W-1:0];
      end
   end

   always_comb begin
      prdata = '0;
      if (reg_index == bia_pkg::REG_RESERVED_COUNT) begin
         prdata = bia_pkg::DATA_W'(reserved_count_ff);
      end
   end

   assign ctx_ok    = (int'(s1_ctx_ff) < bia_pkg::CONTEXT_COUNT);
   assign ctx_idx   = bia_pkg::CTX_W'(s1_ctx_ff);
   assign cur_map   = used_bits_ff[ctx_idx];
   assign cur_count = overflow_count_ff[ctx_idx];
   assign cur_max   = overflow_max_ff[ctx_idx];

   always_comb begin
      for (int i = 0; i < bia_pkg::MAP_BITS; i++) begin
         ge_mask[i] = (i >= int'(reserved_count_ff));
      end
   end

   // The fill mask covers every bit up to and including the first free candidate,
   // or the whole map when there is none.
   assign cand   = ~cur_map & ge_mask;
   assign found  = |cand;
   assign fill   = cand ^ (cand - bia_pkg::map_type'(1));
   assign lowest = cand & fill;

   always_comb begin
      alloc_idx = '0;
      for (int i = 0; i < bia_pkg::MAP_BITS; i++) begin
         if (lowest[i]) begin
            alloc_idx = alloc_idx | bia_pkg::IDX_W'(i);
         end
      end
   end

   assign dec_count = (cur_count != '0) ? cur_count - 1'b1 : cur_count;

   always_comb begin
      map_in          = cur_map;
      count_in        = cur_count;
      max_in          = cur_max;
      exhausted       = 1'b0;
      rsp_given_id_in = '0;
      rsp_status_in   = bia_pkg::STATUS_OK;
      if (!ctx_ok) begin
         rsp_status_in = bia_pkg::STATUS_BAD_CONTEXT;
      end else if (s1_cmd_ff == bia_pkg::CMD_ALLOC) begin
         map_in = cur_map | fill;
         if (found) begin
            rsp_given_id_in = bia_pkg::ID_W'(alloc_idx);
         end else if (cur_count < bia_pkg::ID_W'(reserved_count_ff)) begin
            rsp_given_id_in = bia_pkg::MAP_ID;
            count_in        = bia_pkg::MAP_ID;
            max_in          = bia_pkg::MAP_ID;
         end else if (cur_count == bia_pkg::ID_LIMIT) begin
            exhausted     = 1'b1;
            rsp_status_in = bia_pkg::STATUS_EXHAUSTED;
         end else begin
            rsp_given_id_in = cur_count + 1'b1;
            count_in        = cur_count + 1'b1;
            max_in          = cur_count + 1'b1;
         end
      end else if (s1_rid_ff >= bia_pkg::MAP_ID) begin
         if (s1_rid_ff >= cur_max) begin
            count_in = dec_count;
            max_in   = dec_count;
         end
      end else begin
         map_in = cur_map & ~(bia_pkg::map_type'(1) << s1_rid_ff[bia_pkg::IDX_W-1:0]);
      end
   end

   assign state_we = s1_go && ctx_ok;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff       <= 1'b0;
         rsp_valid_ff      <= 1'b0;
         reserved_count_ff <= bia_pkg::RESERVED_RESET;
         for (int c = 0; c < bia_pkg::CONTEXT_COUNT; c++) begin
            used_bits_ff[c]      <= '0;
            overflow_count_ff[c] <= '0;
            overflow_max_ff[c]   <= '0;
         end
      end else begin
         s1_valid_ff       <= s1_valid_in;
         rsp_valid_ff      <= rsp_valid_in;
         reserved_count_ff <= reserved_count_in;
         if (state_we) begin
            used_bits_ff[ctx_idx]      <= map_in;
            overflow_count_ff[ctx_idx] <= count_in;
            overflow_max_ff[ctx_idx]   <= max_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_cmd_ff <= bia_pkg::cmd_type'(req_cmd);
         s1_ctx_ff <= req_context_req;
         s1_rid_ff <= req_release_id;
      end
      if (s1_go) begin
         rsp_given_id_ff <= rsp_given_id_in;
         rsp_status_ff   <= rsp_status_in;
      end
   end

   `BIA_ASSERT_NOW(a_error_gives_zero_id, clock, reset,
      rsp_valid_ff && (rsp_status_ff != bia_pkg::STATUS_OK), rsp_given_id_ff == '0,
      "A failed request returned a nonzero identifier.")

   `BIA_ASSERT_NOW(a_stall_needs_held_request, clock, reset,
      !s1_valid_ff, !req_stall,
      "The input stalled with no request held.")

   `BIA_ASSERT_NEXT(a_bitmap_id_marked_used, clock, reset,
      state_we && (s1_cmd_ff == bia_pkg::CMD_ALLOC) && found,
      used_bits_ff[$past(ctx_idx)][$past(alloc_idx)],
      "An identifier handed out from the bitmap is not marked used.")

   `BIA_ASSERT_NEXT(a_overflow_max_tracks_count, clock, reset,
      state_we && (s1_cmd_ff == bia_pkg::CMD_ALLOC) && !found && !exhausted,
      overflow_count_ff[$past(ctx_idx)] == overflow_max_ff[$past(ctx_idx)],
      "An overflow allocation left the maximum apart from the counter.")

endmodule

`default_nettype wire

// File: verif/bitmap_id_allocator_with_overflow_tb.sv
// Self-checking testbench for the per-context bitmap identifier allocator.
`timescale 1ns / 100ps

module bitmap_id_allocator_with_overflow_tb;

   localparam int STUCK_LIMIT = 5000;
   localparam int RANDOM_PHASES = 8;
   localparam int PHASE_ITEMS = 200;
   localparam int HOLD_CYCLES = 150;
   localparam logic [bia_pkg::ADDR_W-1:0] RESERVED_ADDR = {bia_pkg::REG_RESERVED_COUNT, 2'b00};

   typedef struct {
      bia_pkg::id_type     given;
      bia_pkg::status_type status;
   } grant_type;

   typedef struct {
      logic [bia_pkg::CTX_IN_W-1:0] ctx;
      bia_pkg::id_type              id;
   } live_id_type;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_valid = 1'b0;
   logic                           req_stall;
   logic                           req_cmd = 1'b0;
   logic [bia_pkg::CTX_IN_W-1:0]   req_context_req = '0;
   logic [bia_pkg::ID_W-1:0]       req_release_id = '0;
   logic                           rsp_valid;
   logic                           rsp_stall = 1'b0;
   logic [bia_pkg::ID_W-1:0]       rsp_given_id;
   logic [bia_pkg::STATUS_W-1:0]   rsp_status;
   logic                           psel = 1'b0;
   logic                           penable = 1'b0;
   logic                           pwrite = 1'b0;
   logic [bia_pkg::ADDR_W-1:0]     paddr = '0;
   logic [bia_pkg::DATA_W-1:0]     pwdata = '0;
   logic [bia_pkg::DATA_W-1:0]     prdata;
   logic                           pready;

   bia_pkg::map_type               ctx_map [bia_pkg::CONTEXT_COUNT];
   bia_pkg::id_type                ctx_ovf_count [bia_pkg::CONTEXT_COUNT];
   bia_pkg::id_type                ctx_ovf_max [bia_pkg::CONTEXT_COUNT];
   logic [bia_pkg::CFG_W-1:0]      reserved_cfg = bia_pkg::RESERVED_RESET;

   grant_type             pending_grants [$];
   live_id_type           live_ids [$];
   grant_type             oldest_grant;
   int                    errors = 0;
   int                    stuck_cycles = 0;
   int                    send_idle_pct = 34;
   int                    recv_idle_pct = 34;
   int                    hold_token = 0;
   int                    hold_seen = 0;
   int                    hold_left = 0;

   bitmap_id_allocator_with_overflow dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_cmd         (req_cmd),
      .req_context_req (req_context_req),
      .req_release_id  (req_release_id),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_given_id    (rsp_given_id),
      .rsp_status      (rsp_status),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .prdata          (prdata),
      .pready          (pready)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic grant_type grant_for_request(input bia_pkg::cmd_type c,
                                                   input logic [bia_pkg::CTX_IN_W-1:0] ctx,
                                                   input bia_pkg::id_type rid);
      grant_type g;
      int unsigned k;
      g.given = '0;
      g.status = bia_pkg::STATUS_OK;
      if (ctx >= bia_pkg::CONTEXT_COUNT) begin
         g.status = bia_pkg::STATUS_BAD_CONTEXT;
         return g;
      end
      if (c == bia_pkg::CMD_ALLOC) begin
         if (!(&ctx_map[ctx])) begin
            for (k = 0; k < bia_pkg::MAP_BITS; k++) begin
               if (!ctx_map[ctx][k]) begin
                  ctx_map[ctx][k] = 1'b1;
                  if (k >= reserved_cfg) begin
                     g.given = bia_pkg::id_type'(k);
                     return g;
                  end
               end
            end
         end
         if (ctx_ovf_count[ctx] < reserved_cfg) begin
            g.given = bia_pkg::MAP_ID;
         end else if (ctx_ovf_count[ctx] == bia_pkg::ID_LIMIT) begin
            g.status = bia_pkg::STATUS_EXHAUSTED;
            return g;
         end else begin
            g.given = ctx_ovf_count[ctx] + 1'b1;
         end
         ctx_ovf_count[ctx] = g.given;
         ctx_ovf_max[ctx] = g.given;
      end else if (rid >= bia_pkg::MAP_ID) begin
         if (rid >= ctx_ovf_max[ctx]) begin
            if (ctx_ovf_count[ctx] != '0) begin
               ctx_ovf_count[ctx] = ctx_ovf_count[ctx] - 1'b1;
            end
            ctx_ovf_max[ctx] = ctx_ovf_count[ctx];
         end
      end else begin
         ctx_map[ctx][rid[bia_pkg::IDX_W-1:0]] = 1'b0;
      end
      return g;
   endfunction

   task automatic send_request(input bia_pkg::cmd_type c,
                               input logic [bia_pkg::CTX_IN_W-1:0] ctx,
                               input bia_pkg::id_type rid);
      grant_type g;
      live_id_type entry;
      @(negedge clock);
      while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_cmd = c;
      req_context_req = ctx;
      req_release_id = rid;
      do @(posedge clock); while (req_stall);
      g = grant_for_request(c, ctx, rid);
      pending_grants.push_back(g);
      if (c == bia_pkg::CMD_ALLOC && g.status == bia_pkg::STATUS_OK
          && live_ids.size() < 512) begin
         entry.ctx = ctx;
         entry.id = g.given;
         live_ids.push_back(entry);
      end
   endtask

   task automatic wait_for_results();
      @(negedge clock);
      req_valid = 1'b0;
      wait (pending_grants.size() == 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reserved(input logic [bia_pkg::CFG_W-1:0] value);
      wait_for_results();
      @(negedge clock);
      psel = 1'b1;
      penable = 1'b0;
      pwrite = 1'b1;
      paddr = RESERVED_ADDR;
      pwdata = bia_pkg::DATA_W'(value);
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (!pready);
      reserved_cfg = value;
      @(negedge clock);
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
   endtask

   always @(negedge clock) begin
      if (hold_token != hold_seen) begin
         hold_left = HOLD_CYCLES;
         hold_seen = hold_token;
      end
      if (hold_left > 0) begin
         rsp_stall = 1'b1;
         hold_left = hold_left - 1;
      end else begin
         rsp_stall = (recv_idle_pct > 0) && ($urandom_range(99) < recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_grants.size() == 0) begin
            $error("result with no request outstanding: given_id %0d status %0d",
                   rsp_given_id, rsp_status);
            errors++;
         end else begin
            oldest_grant = pending_grants.pop_front();
            if (rsp_given_id !== oldest_grant.given) begin
               $error("given_id: expected %0d, actual %0d", oldest_grant.given, rsp_given_id);
               errors++;
            end
            if (rsp_status !== oldest_grant.status) begin
               $error("status: expected %0d, actual %0d", oldest_grant.status, rsp_status);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || psel) begin
         stuck_cycles = 0;
      end else begin
         stuck_cycles++;
      end
      if (stuck_cycles >= STUCK_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   task automatic test_reset_defaults();
      send_request(bia_pkg::CMD_ALLOC, 3'd0, '0);
      send_request(bia_pkg::CMD_ALLOC, 3'd0, 16'hFFFF);
      send_request(bia_pkg::CMD_RELEASE, 3'd0, 16'd2);
      send_request(bia_pkg::CMD_ALLOC, 3'd0, '0);
      send_request(bia_pkg::CMD_RELEASE, 3'd0, 16'd200);
      send_request(bia_pkg::CMD_RELEASE, 3'd0, 16'd0);
      send_request(bia_pkg::CMD_ALLOC, 3'd0, '0);
   endtask

   task automatic test_bad_context();
      send_request(bia_pkg::CMD_ALLOC, 3'd4, '0);
      send_request(bia_pkg::CMD_RELEASE, 3'd7, 16'hFFFF);
      send_request(bia_pkg::CMD_ALLOC, 3'd5, 16'h5555);
      send_request(bia_pkg::CMD_RELEASE, 3'd6, 16'd3);
   endtask

   task automatic test_release_at_zero_count();
      send_request(bia_pkg::CMD_RELEASE, 3'd1, bia_pkg::MAP_ID);
      send_request(bia_pkg::CMD_RELEASE, 3'd1, 16'hFFFF);
   endtask

   task automatic test_reserved_extremes();
      write_reserved(8'd255);
      send_request(bia_pkg::CMD_ALLOC, 3'd2, '0);
      send_request(bia_pkg::CMD_ALLOC, 3'd2, '0);
      send_request(bia_pkg::CMD_ALLOC, 3'd2, '0);
      send_request(bia_pkg::CMD_RELEASE, 3'd2, 16'd100);
      send_request(bia_pkg::CMD_RELEASE, 3'd2, bia_pkg::MAP_ID);
      send_request(bia_pkg::CMD_RELEASE, 3'd2, bia_pkg::MAP_ID + 16'd1);
      send_request(bia_pkg::CMD_RELEASE, 3'd2, 16'hAAAA);
      send_request(bia_pkg::CMD_ALLOC, 3'd2, '0);
      write_reserved(8'd0);
      send_request(bia_pkg::CMD_ALLOC, 3'd3, '0);
      write_reserved(bia_pkg::RESERVED_RESET);
   endtask

   task automatic test_output_backpressure();
      int n;
      wait_for_results();
      send_idle_pct = 0;
      hold_token++;
      for (n = 0; n < 40; n++) begin
         send_request(bia_pkg::cmd_type'($urandom_range(1)),
                      bia_pkg::CTX_IN_W'($urandom_range(3)),
                      bia_pkg::id_type'($urandom_range(300)));
      end
      send_idle_pct = 34;
      wait_for_results();
   endtask

   task automatic test_random_traffic();
      int phase;
      int n;
      int alloc_pct;
      int focus;
      int pick;
      bia_pkg::cmd_type c;
      logic [bia_pkg::CTX_IN_W-1:0] ctx;
      bia_pkg::id_type rid;
      live_id_type entry;
      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         case ($urandom_range(3))
            0: write_reserved($urandom_range(1) ? 8'd255 : 8'd0);
            1: write_reserved(bia_pkg::CFG_W'($urandom_range(255, 200)));
            2: write_reserved(bia_pkg::CFG_W'($urandom_range(16)));
            default: write_reserved(bia_pkg::CFG_W'($urandom_range(255)));
         endcase
         send_idle_pct = (phase == 1) ? 0 : 34;
         recv_idle_pct = (phase == 1) ? 0 : 34;
         case ($urandom_range(2))
            0: alloc_pct = 50;
            1: alloc_pct = 75;
            default: alloc_pct = 90;
         endcase
         focus = $urandom_range(bia_pkg::CONTEXT_COUNT - 1);
         for (n = 0; n < PHASE_ITEMS; n++) begin
            if ($urandom_range(99) < 5) begin
               ctx = bia_pkg::CTX_IN_W'($urandom_range(7, bia_pkg::CONTEXT_COUNT));
            end else if ($urandom_range(99) < 70) begin
               ctx = bia_pkg::CTX_IN_W'(focus);
            end else begin
               ctx = bia_pkg::CTX_IN_W'($urandom_range(bia_pkg::CONTEXT_COUNT - 1));
            end
            c = ($urandom_range(99) < alloc_pct) ? bia_pkg::CMD_ALLOC : bia_pkg::CMD_RELEASE;
            rid = bia_pkg::id_type'($urandom_range(65535));
            pick = $urandom_range(9);
            if (c == bia_pkg::CMD_RELEASE && ctx < bia_pkg::CONTEXT_COUNT) begin
               if (pick < 4 && live_ids.size() > 0) begin
                  pick = $urandom_range(live_ids.size() - 1);
                  entry = live_ids[pick];
                  live_ids.delete(pick);
                  ctx = entry.ctx;
                  rid = entry.id;
               end else if (pick < 6) begin
                  rid = ctx_ovf_max[ctx] + bia_pkg::id_type'($urandom_range(2)) - 1'b1;
               end else if (pick < 8) begin
                  rid = bia_pkg::id_type'($urandom_range(bia_pkg::MAP_BITS - 1));
               end
            end
            send_request(c, ctx, rid);
         end
      end
      send_idle_pct = 34;
      recv_idle_pct = 34;
   endtask

   initial begin
      for (int k = 0; k < bia_pkg::CONTEXT_COUNT; k++) begin
         ctx_map[k] = '0;
         ctx_ovf_count[k] = '0;
         ctx_ovf_max[k] = '0;
      end
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_reset_defaults();
      test_bad_context();
      test_release_at_zero_count();
      test_reserved_extremes();
      test_output_backpressure();
      test_random_traffic();
      wait_for_results();
      if (errors == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
